FILE: rtl/core/cid_pkg.sv
package cid_pkg;

	// Field widths of one request and one result.
	localparam int unsigned WordW = 32;
	localparam int unsigned LineW = 32;
	localparam int unsigned RegW  = 6;
	localparam int unsigned MnW   = 6;
	localparam int unsigned CntW  = 2;
	localparam int unsigned ErrW  = 2;

	// Major opcodes, bits 4:0 of the word.
	localparam logic [4:0] OP_LOAD   = 5'h00;
	localparam logic [4:0] OP_IMM    = 5'h04;
	localparam logic [4:0] OP_STORE  = 5'h08;
	localparam logic [4:0] OP_INT_R  = 5'h0c;
	localparam logic [4:0] OP_LUI    = 5'h0d;
	localparam logic [4:0] OP_FLT_R  = 5'h14;
	localparam logic [4:0] OP_BRANCH = 5'h18;
	localparam logic [4:0] OP_JALR   = 5'h19;
	localparam logic [4:0] OP_JAL    = 5'h1b;

	// funct7 codes of the float group.
	localparam logic [5:0] F7_FADD  = 6'h00;
	localparam logic [5:0] F7_FSUB  = 6'h02;
	localparam logic [5:0] F7_FMUL  = 6'h04;
	localparam logic [5:0] F7_FDIV  = 6'h06;
	localparam logic [5:0] F7_FLE   = 6'h28;
	localparam logic [5:0] F7_FEQ   = 6'h38;
	localparam logic [5:0] F7_FSQRT = 6'h16;
	localparam logic [5:0] F7_FLOOR = 6'h0a;
	localparam logic [5:0] F7_ITOF  = 6'h34;
	localparam logic [5:0] F7_FTOI  = 6'h3c;

	typedef enum logic [MnW-1:0] {
		MN_ADD   = 6'd0,  MN_AND   = 6'd1,  MN_OR    = 6'd2,  MN_XOR   = 6'd3,
		MN_SLL   = 6'd4,  MN_SRA   = 6'd5,  MN_SUB   = 6'd6,  MN_SLT   = 6'd7,
		MN_SLTU  = 6'd8,  MN_SRL   = 6'd9,  MN_SLLI  = 6'd10, MN_SRLI  = 6'd11,
		MN_SRAI  = 6'd12, MN_NOP   = 6'd13, MN_ADDI  = 6'd14, MN_ANDI  = 6'd15,
		MN_ORI   = 6'd16, MN_XORI  = 6'd17, MN_JALR  = 6'd18, MN_JR    = 6'd19,
		MN_LW    = 6'd20, MN_LBU   = 6'd21, MN_BLT   = 6'd22, MN_BEQ   = 6'd23,
		MN_BNE   = 6'd24, MN_BGE   = 6'd25, MN_J     = 6'd26, MN_JAL   = 6'd27,
		MN_SW    = 6'd28, MN_SB    = 6'd29, MN_FADD  = 6'd30, MN_FSUB  = 6'd31,
		MN_FMUL  = 6'd32, MN_FDIV  = 6'd33, MN_FLE   = 6'd34, MN_FEQ   = 6'd35,
		MN_FSQRT = 6'd36, MN_FLOOR = 6'd37, MN_ITOF  = 6'd38, MN_FTOI  = 6'd39,
		MN_LUI   = 6'd40
	} mnem_t;

	typedef enum logic [ErrW-1:0] {
		ERR_NONE   = 2'd0,
		ERR_SUBENC = 2'd1,
		ERR_UNIMPL = 2'd2
	} err_t;

	typedef struct packed {
		mnem_t             mnemonic;
		logic [RegW-1:0]   first_reg;
		logic [RegW-1:0]   second_reg;
		logic [RegW-1:0]   third_reg;
		logic [WordW-1:0]  immediate_value;
		logic [CntW-1:0]   operand_count;
		err_t              error_code;
	} dec_t;

endpackage

FILE: rtl/core/custom_isa_instruction_decoder.sv
// Instruction decoder for the custom RISC-V-like ISA.
// Input channel (s_*): one request per accepted beat carries a 32-bit instruction
// word and a 32-bit program line number. Output channel (m_*): one result per
// request, in order, with the mnemonic number, up to three register indices,
// the sign-extended immediate, the operand count, an error code and the line
// number copied from the request.
// The request is captured in the input register, decoded by combinational
// logic and captured in the result register, from which it is shown.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more request, so s_tready drops only when both
// registers are full and m_tready is low. Reset clears both valid flags; no
// request is pending afterwards and s_tready is high.
module custom_isa_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] instruction_word, [63:32] line_number
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata   // [5:0] mnemonic, [11:6] first_reg, [17:12] second_reg,
	                              // [23:18] third_reg, [55:24] immediate_value,
	                              // [57:56] operand_count, [59:58] error_code,
	                              // [91:60] line_out, [95:92] zero
);

	logic                          valid_s1;
	logic [cid_pkg::WordW-1:0]     word_s1;
	logic [cid_pkg::LineW-1:0]     line_s1;
	logic                          valid_s2;
	cid_pkg::dec_t                 dec_s2;
	logic [cid_pkg::LineW-1:0]     line_s2;
	cid_pkg::dec_t                 dec_comb;
	logic                          adv_s2;
	logic                          take_s1;

	// The result register can load whenever it is empty or being drained.
	assign adv_s2  = !valid_s2 || m_tready;
	// The input register can load whenever it is empty or its content moves on this cycle.
	assign s_tready = !valid_s1 || adv_s2;
	assign take_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			word_s1 <= s_tdata[31:0];
			line_s1 <= s_tdata[63:32];
		end
	end

	cid_decode u_decode (
		.word (word_s1),
		.dec  (dec_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			dec_s2  <= dec_comb;
			line_s2 <= line_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0,
	                   line_s2,
	                   dec_s2.error_code,
	                   dec_s2.operand_count,
	                   dec_s2.immediate_value,
	                   dec_s2.third_reg,
	                   dec_s2.second_reg,
	                   dec_s2.first_reg,
	                   dec_s2.mnemonic};

endmodule

FILE: rtl/core/cid_decode.sv
module cid_decode (
	input  logic [cid_pkg::WordW-1:0] word,
	output cid_pkg::dec_t             dec
);

	logic [4:0] op;
	logic [5:0] rd;
	logic [5:0] rs1;
	logic [5:0] rs2;
	logic [2:0] f3;
	logic [5:0] f7;
	logic [31:0] imm_i;
	logic [31:0] imm_b;
	logic [31:0] imm_s;
	logic [31:0] imm_j;
	logic [31:0] imm_sh;
	logic [31:0] imm_u;
	cid_pkg::dec_t raw;

	assign op  = word[4:0];
	assign rd  = word[10:5];
	assign f3  = word[13:11];
	assign rs1 = word[19:14];
	assign rs2 = word[25:20];
	assign f7  = word[31:26];

	assign imm_i  = {{20{word[31]}}, word[31:20]};
	assign imm_b  = {{18{word[31]}}, word[31:26], word[10:5], 2'b00};
	assign imm_s  = {{20{word[31]}}, word[31:26], word[10:5]};
	assign imm_j  = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
	assign imm_sh = {27'd0, word[24:20]};
	assign imm_u  = {word[31:11], 11'd0};

	always_comb begin
		raw = '0;
		raw.mnemonic = cid_pkg::MN_ADD;
		raw.error_code = cid_pkg::ERR_NONE;
		unique case (op)
			cid_pkg::OP_INT_R: begin
				raw.first_reg = rd;
				raw.second_reg = rs1;
				raw.third_reg = rs2;
				raw.operand_count = 2'd3;
				if (f7 == 6'd1) begin
					if (f3 == 3'd3) raw.mnemonic = cid_pkg::MN_SLTU;
					else if (f3 == 3'd5) raw.mnemonic = cid_pkg::MN_SRL;
					else raw.error_code = cid_pkg::ERR_SUBENC;
				end else if (f7 == 6'd0) begin
					unique case (f3)
						3'd0: raw.mnemonic = cid_pkg::MN_ADD;
						3'd1: raw.mnemonic = cid_pkg::MN_SLL;
						3'd2: raw.mnemonic = cid_pkg::MN_SUB;
						3'd3: raw.mnemonic = cid_pkg::MN_SLT;
						3'd4: raw.mnemonic = cid_pkg::MN_XOR;
						3'd5: raw.mnemonic = cid_pkg::MN_SRA;
						3'd6: raw.mnemonic = cid_pkg::MN_OR;
						default: raw.mnemonic = cid_pkg::MN_AND;
					endcase
				end else begin
					raw.error_code = cid_pkg::ERR_SUBENC;
				end
			end
			cid_pkg::OP_IMM: begin
				raw.first_reg = rd;
				raw.second_reg = rs1;
				raw.operand_count = 2'd2;
				if (f3[1:0] == 2'b01) begin
					raw.immediate_value = imm_sh;
					if (f3 == 3'd1) raw.mnemonic = cid_pkg::MN_SLLI;
					else if (f7 == 6'd1) raw.mnemonic = cid_pkg::MN_SRLI;
					else if (f7 == 6'd0) raw.mnemonic = cid_pkg::MN_SRAI;
					else raw.error_code = cid_pkg::ERR_SUBENC;
				end else begin
					raw.immediate_value = imm_i;
					unique case (f3)
						3'd0: raw.mnemonic = (rd == 6'd0) ? cid_pkg::MN_NOP : cid_pkg::MN_ADDI;
						3'd7: raw.mnemonic = cid_pkg::MN_ANDI;
						3'd6: raw.mnemonic = cid_pkg::MN_ORI;
						3'd4: raw.mnemonic = cid_pkg::MN_XORI;
						default: raw.error_code = cid_pkg::ERR_SUBENC;
					endcase
				end
			end
			cid_pkg::OP_BRANCH: begin
				raw.first_reg = rs1;
				raw.second_reg = rs2;
				raw.operand_count = 2'd2;
				raw.immediate_value = imm_b;
				unique case (f3)
					3'd4: raw.mnemonic = cid_pkg::MN_BLT;
					3'd0: raw.mnemonic = cid_pkg::MN_BEQ;
					3'd1: raw.mnemonic = cid_pkg::MN_BNE;
					3'd6: raw.mnemonic = cid_pkg::MN_BGE;
					default: raw.error_code = cid_pkg::ERR_SUBENC;
				endcase
			end
			cid_pkg::OP_JAL: begin
				raw.first_reg = rd;
				raw.operand_count = 2'd2;
				raw.immediate_value = imm_j;
				raw.mnemonic = (rd == 6'd0) ? cid_pkg::MN_J : cid_pkg::MN_JAL;
			end
			cid_pkg::OP_JALR: begin
				raw.immediate_value = imm_i;
				if (f3 != 3'd0) begin
					raw.error_code = cid_pkg::ERR_SUBENC;
				end else if (rd != 6'd0) begin
					raw.mnemonic = cid_pkg::MN_JALR;
					raw.first_reg = rd;
					raw.second_reg = rs1;
					raw.operand_count = 2'd2;
				end else begin
					// With no link register the jump takes only its base register.
					raw.mnemonic = cid_pkg::MN_JR;
					raw.first_reg = rs1;
					raw.operand_count = 2'd1;
				end
			end
			cid_pkg::OP_LOAD: begin
				raw.first_reg = rd;
				raw.second_reg = rs1;
				raw.operand_count = 2'd2;
				raw.immediate_value = imm_i;
				if (f3 == 3'd2) raw.mnemonic = cid_pkg::MN_LW;
				else if (f3 == 3'd4) raw.mnemonic = cid_pkg::MN_LBU;
				else raw.error_code = cid_pkg::ERR_SUBENC;
			end
			cid_pkg::OP_STORE: begin
				raw.first_reg = rs2;
				raw.second_reg = rs1;
				raw.operand_count = 2'd2;
				raw.immediate_value = imm_s;
				if (f3 == 3'd2) raw.mnemonic = cid_pkg::MN_SW;
				else if (f3 == 3'd4) raw.mnemonic = cid_pkg::MN_SB;
				else raw.error_code = cid_pkg::ERR_SUBENC;
			end
			cid_pkg::OP_FLT_R: begin
				raw.first_reg = rd;
				raw.second_reg = rs1;
				raw.third_reg = rs2;
				raw.operand_count = 2'd3;
				if (f3 != 3'd0) begin
					raw.error_code = cid_pkg::ERR_SUBENC;
				end else begin
					unique case (f7)
						cid_pkg::F7_FADD: raw.mnemonic = cid_pkg::MN_FADD;
						cid_pkg::F7_FSUB: raw.mnemonic = cid_pkg::MN_FSUB;
						cid_pkg::F7_FMUL: raw.mnemonic = cid_pkg::MN_FMUL;
						cid_pkg::F7_FDIV: raw.mnemonic = cid_pkg::MN_FDIV;
						cid_pkg::F7_FLE:  raw.mnemonic = cid_pkg::MN_FLE;
						cid_pkg::F7_FEQ:  raw.mnemonic = cid_pkg::MN_FEQ;
						default: begin
							// Single-source float ops require an all-zero rs2 field.
							raw.operand_count = 2'd2;
							if (rs2 != 6'd0) raw.error_code = cid_pkg::ERR_SUBENC;
							else if (f7 == cid_pkg::F7_FSQRT) raw.mnemonic = cid_pkg::MN_FSQRT;
							else if (f7 == cid_pkg::F7_FLOOR) raw.mnemonic = cid_pkg::MN_FLOOR;
							else if (f7 == cid_pkg::F7_ITOF) raw.mnemonic = cid_pkg::MN_ITOF;
							else if (f7 == cid_pkg::F7_FTOI) raw.mnemonic = cid_pkg::MN_FTOI;
							else raw.error_code = cid_pkg::ERR_SUBENC;
						end
					endcase
				end
			end
			cid_pkg::OP_LUI: begin
				raw.first_reg = rd;
				raw.operand_count = 2'd1;
				raw.immediate_value = imm_u;
				raw.mnemonic = cid_pkg::MN_LUI;
			end
			default: raw.error_code = cid_pkg::ERR_UNIMPL;
		endcase
	end

	// A rejected word reports only its error code.
	always_comb begin
		dec = raw;
		if (raw.error_code != cid_pkg::ERR_NONE) begin
			dec = '0;
			dec.mnemonic = cid_pkg::MN_ADD;
			dec.error_code = raw.error_code;
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Random requests after the directed table, and how many at the end run
	// with no idling on either side.
	localparam int RandomRequests = 1425;
	localparam int QuietTail      = 200;
	// The decoder is two registers deep, so this stretch of silence after the last
	// result is plenty to catch a stray extra beat.
	localparam int DrainCycles    = 10;
	// Longest honest stretch with no beat on either side is a sender gap plus a
	// receiver stall plus the pipeline.
	localparam int WatchdogLimit  = 1000;

	// funct3 codes, grouped by the major opcode that gives them meaning.
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SUB  = 3'd2;
	localparam logic [2:0] F3_SLT  = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRA  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd6;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_BYTE = 3'd4;
	localparam logic [2:0] F3_NONE = 3'd0;
	// funct7 of the integer register group and of the right shifts.
	localparam logic [5:0] F7_BASE = 6'd0;
	localparam logic [5:0] F7_ALT  = 6'd1;

	// One decoded result, in the order the fields sit in m_tdata.
	typedef struct packed {
		cid_pkg::mnem_t mn;
		logic [5:0]     r0;
		logic [5:0]     r1;
		logic [5:0]     r2;
		logic [31:0]    imm;
		logic [1:0]     cnt;
		cid_pkg::err_t  err;
		logic [31:0]    line;
	} decode_result_t;

	// A row of the directed table. Rows with a typed answer are checked against
	// that answer; the rest go through the predictor like the random requests.
	typedef struct {
		logic [31:0]    word;
		logic [31:0]    line;
		logic           typed;
		decode_result_t want;
	} stim_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;  // [31:0] instruction_word, [63:32] line_number
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;        // [5:0] mnemonic, [11:6] first_reg, [17:12] second_reg,
	                             // [23:18] third_reg, [55:24] immediate_value,
	                             // [57:56] operand_count, [59:58] error_code,
	                             // [91:60] line_out, [95:92] zero

	decode_result_t pending_decodes[$];
	int             error_count    = 0;
	int             sent_count     = 0;
	int             checked_count  = 0;
	int             subenc_count   = 0;
	int             unimpl_count   = 0;
	int             quiet_cycles   = 0;
	int             stall_left     = 0;
	bit             quiet_tail     = 1'b0;
	logic [40:0]    seen_mnemonics = '0;

	// Directed requests: the all-zero and all-one words, each special case of the
	// decode, and several kinds of invalid sub-encoding. Words are built as
	// {funct7, rs2, rs1, funct3, rd, opcode}.
	stim_row_t directed_rows [26] = '{
		// All zeros is a load with an unused width code.
		'{32'h0000_0000, 32'h0000_0000, 1'b1,
			'{cid_pkg::MN_ADD, 6'd0, 6'd0, 6'd0, 32'd0, 2'd0, cid_pkg::ERR_SUBENC,
			  32'h0000_0000}},
		// All ones lands on an opcode that is not implemented.
		'{32'hffff_ffff, 32'hffff_ffff, 1'b1,
			'{cid_pkg::MN_ADD, 6'd0, 6'd0, 6'd0, 32'd0, 2'd0, cid_pkg::ERR_UNIMPL,
			  32'hffff_ffff}},
		'{{F7_BASE, 6'd63, 6'd63, F3_ADD, 6'd63, cid_pkg::OP_INT_R}, 32'h0000_0001,
			1'b0, '0},
		'{{F7_BASE, 6'd1, 6'd2, F3_SUB, 6'd3, cid_pkg::OP_INT_R}, 32'h0000_0002,
			1'b0, '0},
		// The alternate funct7 turns slt into sltu and sra into srl.
		'{{F7_ALT, 6'd4, 6'd5, F3_SLT, 6'd6, cid_pkg::OP_INT_R}, 32'h0000_0003,
			1'b0, '0},
		'{{F7_ALT, 6'd7, 6'd8, F3_SRA, 6'd9, cid_pkg::OP_INT_R}, 32'h0000_0004,
			1'b0, '0},
		'{{F7_ALT, 6'd7, 6'd8, F3_ADD, 6'd9, cid_pkg::OP_INT_R}, 32'h0000_0007, 1'b1,
			'{cid_pkg::MN_ADD, 6'd0, 6'd0, 6'd0, 32'd0, 2'd0, cid_pkg::ERR_SUBENC,
			  32'h0000_0007}},
		'{{6'd63, 6'd7, 6'd8, F3_AND, 6'd9, cid_pkg::OP_INT_R}, 32'h0000_0008, 1'b1,
			'{cid_pkg::MN_ADD, 6'd0, 6'd0, 6'd0, 32'd0, 2'd0, cid_pkg::ERR_SUBENC,
			  32'h0000_0008}},
		// addi into register zero is a nop; the largest positive immediate.
		'{{6'h1f, 6'h3f, 6'd10, F3_ADD, 6'd0, cid_pkg::OP_IMM}, 32'h0000_0009,
			1'b0, '0},
		// addi with the most negative immediate.
		'{{6'h20, 6'd0, 6'd1, F3_ADD, 6'd5, cid_pkg::OP_IMM}, 32'h7fff_ffff,
			1'b0, '0},
		'{{F7_BASE, 6'd31, 6'd2, F3_SRA, 6'd3, cid_pkg::OP_IMM}, 32'h0000_000b,
			1'b0, '0},
		'{{F7_ALT, 6'd63, 6'd2, F3_SRA, 6'd3, cid_pkg::OP_IMM}, 32'h0000_000c,
			1'b0, '0},
		// slli ignores funct7 altogether.
		'{{6'd63, 6'd17, 6'd4, F3_SLL, 6'd9, cid_pkg::OP_IMM}, 32'h0000_000d,
			1'b0, '0},
		'{{6'd2, 6'd17, 6'd4, F3_SRA, 6'd9, cid_pkg::OP_IMM}, 32'h0000_000e, 1'b1,
			'{cid_pkg::MN_ADD, 6'd0, 6'd0, 6'd0, 32'd0, 2'd0, cid_pkg::ERR_SUBENC,
			  32'h0000_000e}},
		// jalr into register zero becomes jr with rs1 moved to the front.
		'{{6'h3f, 6'h3f, 6'd12, F3_NONE, 6'd0, cid_pkg::OP_JALR}, 32'h0000_000f,
			1'b0, '0},
		'{{6'h01, 6'h02, 6'd12, F3_NONE, 6'd7, cid_pkg::OP_JALR}, 32'h0000_0010,
			1'b0, '0},
		'{{6'h01, 6'h02, 6'd12, F3_SLL, 6'd7, cid_pkg::OP_JALR}, 32'h0000_0011, 1'b1,
			'{cid_pkg::MN_ADD, 6'd0, 6'd0, 6'd0, 32'd0, 2'd0, cid_pkg::ERR_SUBENC,
			  32'h0000_0011}},
		// jal into register zero becomes j, with a negative offset here.
		'{{6'h20, 6'h15, 6'h2a, 3'b101, 6'd0, cid_pkg::OP_JAL}, 32'h0000_0012,
			1'b0, '0},
		'{{6'h1f, 6'h3f, 6'h3f, 3'b111, 6'd9, cid_pkg::OP_JAL}, 32'h0000_0013,
			1'b0, '0},
		'{{6'h3f, 6'd8, 6'd9, F3_BGE, 6'h3f, cid_pkg::OP_BRANCH}, 32'h0000_0014,
			1'b0, '0},
		'{{6'h3f, 6'd8, 6'd9, 3'd2, 6'h3f, cid_pkg::OP_BRANCH}, 32'h0000_0015, 1'b1,
			'{cid_pkg::MN_ADD, 6'd0, 6'd0, 6'd0, 32'd0, 2'd0, cid_pkg::ERR_SUBENC,
			  32'h0000_0015}},
		'{{6'h20, 6'd11, 6'd12, F3_BYTE, 6'h01, cid_pkg::OP_STORE}, 32'h0000_0016,
			1'b0, '0},
		'{{6'h3f, 6'h3f, 6'h3f, 3'b111, 6'd63, cid_pkg::OP_LUI}, 32'h0000_0017,
			1'b0, '0},
		// Two-operand float ops are fine with rs2 zero and invalid otherwise.
		'{{cid_pkg::F7_FSQRT, 6'd0, 6'd13, F3_NONE, 6'd14, cid_pkg::OP_FLT_R},
			32'h0000_0018, 1'b0, '0},
		'{{cid_pkg::F7_FTOI, 6'd1, 6'd13, F3_NONE, 6'd14, cid_pkg::OP_FLT_R},
			32'h0000_0019, 1'b1,
			'{cid_pkg::MN_ADD, 6'd0, 6'd0, 6'd0, 32'd0, 2'd0, cid_pkg::ERR_SUBENC,
			  32'h0000_0019}},
		// Any non-zero funct3 in the float group is invalid.
		'{{cid_pkg::F7_FADD, 6'd1, 6'd2, 3'd7, 6'd3, cid_pkg::OP_FLT_R},
			32'h8000_0000, 1'b1,
			'{cid_pkg::MN_ADD, 6'd0, 6'd0, 6'd0, 32'd0, 2'd0, cid_pkg::ERR_SUBENC,
			  32'h8000_0000}}
	};

	custom_isa_instruction_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected decode of one instruction word. Fields are pulled out of the word
	// by position, the major opcode picks the format, and the sub-encoding picks
	// the mnemonic. Any error wipes everything but the error code and the line.
	function automatic decode_result_t predict_decode(input logic [31:0] w,
	                                                  input logic [31:0] line);
		decode_result_t r;
		cid_pkg::err_t  e;
		logic [4:0]     op;
		logic [5:0]     rd;
		logic [5:0]     rs1;
		logic [5:0]     rs2;
		logic [5:0]     f7;
		logic [2:0]     f3;
		logic [31:0]    imm_i;
		op    = w[4:0];
		rd    = w[10:5];
		f3    = w[13:11];
		rs1   = w[19:14];
		rs2   = w[25:20];
		f7    = w[31:26];
		imm_i = {{20{w[31]}}, w[31:20]};
		r     = '0;
		r.err = cid_pkg::ERR_NONE;
		case (op)
			cid_pkg::OP_INT_R: begin
				r.r0  = rd;
				r.r1  = rs1;
				r.r2  = rs2;
				r.cnt = 2'd3;
				if (f7 == F7_ALT) begin
					if (f3 == F3_SLT) r.mn = cid_pkg::MN_SLTU;
					else if (f3 == F3_SRA) r.mn = cid_pkg::MN_SRL;
					else r.err = cid_pkg::ERR_SUBENC;
				end else if (f7 == F7_BASE) begin
					case (f3)
						F3_ADD:  r.mn = cid_pkg::MN_ADD;
						F3_SLL:  r.mn = cid_pkg::MN_SLL;
						F3_SUB:  r.mn = cid_pkg::MN_SUB;
						F3_SLT:  r.mn = cid_pkg::MN_SLT;
						F3_XOR:  r.mn = cid_pkg::MN_XOR;
						F3_SRA:  r.mn = cid_pkg::MN_SRA;
						F3_OR:   r.mn = cid_pkg::MN_OR;
						default: r.mn = cid_pkg::MN_AND;
					endcase
				end else begin
					r.err = cid_pkg::ERR_SUBENC;
				end
			end
			cid_pkg::OP_IMM: begin
				r.r0  = rd;
				r.r1  = rs1;
				r.cnt = 2'd2;
				// Both shift codes end in binary 01; the amount is five bits.
				if (f3 == F3_SLL || f3 == F3_SRA) begin
					r.imm = {27'd0, w[24:20]};
					if (f3 == F3_SLL) r.mn = cid_pkg::MN_SLLI;
					else if (f7 == F7_ALT) r.mn = cid_pkg::MN_SRLI;
					else if (f7 == F7_BASE) r.mn = cid_pkg::MN_SRAI;
					else r.err = cid_pkg::ERR_SUBENC;
				end else begin
					r.imm = imm_i;
					case (f3)
						F3_ADD:  r.mn = (rd == 6'd0) ? cid_pkg::MN_NOP : cid_pkg::MN_ADDI;
						F3_AND:  r.mn = cid_pkg::MN_ANDI;
						F3_OR:   r.mn = cid_pkg::MN_ORI;
						F3_XOR:  r.mn = cid_pkg::MN_XORI;
						default: r.err = cid_pkg::ERR_SUBENC;
					endcase
				end
			end
			cid_pkg::OP_BRANCH: begin
				r.r0  = rs1;
				r.r1  = rs2;
				r.cnt = 2'd2;
				r.imm = {{18{w[31]}}, w[31:26], w[10:5], 2'b00};
				case (f3)
					F3_BLT:  r.mn = cid_pkg::MN_BLT;
					F3_BEQ:  r.mn = cid_pkg::MN_BEQ;
					F3_BNE:  r.mn = cid_pkg::MN_BNE;
					F3_BGE:  r.mn = cid_pkg::MN_BGE;
					default: r.err = cid_pkg::ERR_SUBENC;
				endcase
			end
			cid_pkg::OP_JAL: begin
				r.r0  = rd;
				r.cnt = 2'd2;
				r.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
				r.mn  = (rd == 6'd0) ? cid_pkg::MN_J : cid_pkg::MN_JAL;
			end
			cid_pkg::OP_JALR: begin
				r.imm = imm_i;
				if (f3 != F3_NONE) begin
					r.err = cid_pkg::ERR_SUBENC;
				end else if (rd != 6'd0) begin
					r.mn  = cid_pkg::MN_JALR;
					r.r0  = rd;
					r.r1  = rs1;
					r.cnt = 2'd2;
				end else begin
					r.mn  = cid_pkg::MN_JR;
					r.r0  = rs1;
					r.cnt = 2'd1;
				end
			end
			cid_pkg::OP_LOAD: begin
				r.r0  = rd;
				r.r1  = rs1;
				r.cnt = 2'd2;
				r.imm = imm_i;
				if (f3 == F3_WORD) r.mn = cid_pkg::MN_LW;
				else if (f3 == F3_BYTE) r.mn = cid_pkg::MN_LBU;
				else r.err = cid_pkg::ERR_SUBENC;
			end
			cid_pkg::OP_STORE: begin
				// The data register comes first, the address register second.
				r.r0  = rs2;
				r.r1  = rs1;
				r.cnt = 2'd2;
				r.imm = {{20{w[31]}}, w[31:26], w[10:5]};
				if (f3 == F3_WORD) r.mn = cid_pkg::MN_SW;
				else if (f3 == F3_BYTE) r.mn = cid_pkg::MN_SB;
				else r.err = cid_pkg::ERR_SUBENC;
			end
			cid_pkg::OP_FLT_R: begin
				r.r0  = rd;
				r.r1  = rs1;
				r.r2  = rs2;
				r.cnt = 2'd3;
				if (f3 != F3_NONE) begin
					r.err = cid_pkg::ERR_SUBENC;
				end else begin
					case (f7)
						cid_pkg::F7_FADD: r.mn = cid_pkg::MN_FADD;
						cid_pkg::F7_FSUB: r.mn = cid_pkg::MN_FSUB;
						cid_pkg::F7_FMUL: r.mn = cid_pkg::MN_FMUL;
						cid_pkg::F7_FDIV: r.mn = cid_pkg::MN_FDIV;
						cid_pkg::F7_FLE:  r.mn = cid_pkg::MN_FLE;
						cid_pkg::F7_FEQ:  r.mn = cid_pkg::MN_FEQ;
						default: begin
							r.cnt = 2'd2;
							if (rs2 != 6'd0) r.err = cid_pkg::ERR_SUBENC;
							else if (f7 == cid_pkg::F7_FSQRT) r.mn = cid_pkg::MN_FSQRT;
							else if (f7 == cid_pkg::F7_FLOOR) r.mn = cid_pkg::MN_FLOOR;
							else if (f7 == cid_pkg::F7_ITOF) r.mn = cid_pkg::MN_ITOF;
							else if (f7 == cid_pkg::F7_FTOI) r.mn = cid_pkg::MN_FTOI;
							else r.err = cid_pkg::ERR_SUBENC;
						end
					endcase
				end
			end
			cid_pkg::OP_LUI: begin
				r.r0  = rd;
				r.cnt = 2'd1;
				r.imm = {w[31:11], 11'd0};
				r.mn  = cid_pkg::MN_LUI;
			end
			default: r.err = cid_pkg::ERR_UNIMPL;
		endcase
		if (r.err != cid_pkg::ERR_NONE) begin
			e     = r.err;
			r     = '0;
			r.err = e;
		end
		r.line = line;
		return r;
	endfunction

	// Random instruction word. Most draws pick one of the decoded opcodes and
	// then steer funct3, funct7, rd and rs2 toward the values that reach the
	// interesting branches; one draw in ten keeps the raw random word as noise.
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 9))
			0: w[4:0] = cid_pkg::OP_LOAD;
			1: w[4:0] = cid_pkg::OP_IMM;
			2: w[4:0] = cid_pkg::OP_STORE;
			3: w[4:0] = cid_pkg::OP_INT_R;
			4: w[4:0] = cid_pkg::OP_LUI;
			5: w[4:0] = cid_pkg::OP_FLT_R;
			6: w[4:0] = cid_pkg::OP_BRANCH;
			7: w[4:0] = cid_pkg::OP_JALR;
			8: w[4:0] = cid_pkg::OP_JAL;
			default: return w;
		endcase
		if ($urandom_range(0, 5) == 0) w[10:5] = 6'd0;
		case (w[4:0])
			cid_pkg::OP_INT_R, cid_pkg::OP_IMM: begin
				// Keep funct7 at zero or one most of the time.
				if ($urandom_range(0, 3) != 0) w[31:27] = 5'd0;
			end
			cid_pkg::OP_JALR: begin
				if ($urandom_range(0, 3) != 0) w[13:11] = F3_NONE;
			end
			cid_pkg::OP_FLT_R: begin
				if ($urandom_range(0, 3) != 0) w[13:11] = F3_NONE;
				case ($urandom_range(0, 10))
					0: w[31:26] = cid_pkg::F7_FADD;
					1: w[31:26] = cid_pkg::F7_FSUB;
					2: w[31:26] = cid_pkg::F7_FMUL;
					3: w[31:26] = cid_pkg::F7_FDIV;
					4: w[31:26] = cid_pkg::F7_FLE;
					5: w[31:26] = cid_pkg::F7_FEQ;
					6: w[31:26] = cid_pkg::F7_FSQRT;
					7: w[31:26] = cid_pkg::F7_FLOOR;
					8: w[31:26] = cid_pkg::F7_ITOF;
					9: w[31:26] = cid_pkg::F7_FTOI;
					default: ;
				endcase
				if ($urandom_range(0, 1) == 0) w[25:20] = 6'd0;
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR at %0t ns, result %0d: %s", $time, checked_count, msg);
	endtask

	task automatic compare_field(input string field, input logic [31:0] got,
	                             input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
	endtask

	// Holds the input side quiet, with junk on the data lines so that a beat
	// taken without tvalid would show up as a wrong result.
	task automatic idle_input(input int n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
		end
	endtask

	// Offers one request and waits for the handshake. The expected decode is
	// queued at the accepting edge, ahead of any result it can cause.
	task automatic send_request(input logic [31:0] word, input logic [31:0] line,
	                            input logic typed, input decode_result_t typed_want);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {line, word};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_decodes.push_back(typed ? typed_want : predict_decode(word, line));
		sent_count++;
	endtask

	// Receiver: stalls in random bursts of random length, none in the tail.
	always @(negedge clk) begin
		if (stall_left == 0 && !quiet_tail && $urandom_range(0, 6) == 0)
			stall_left = $urandom_range(1, 9);
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result checker and watchdog. Everything is sampled at the rising edge, so
	// the values seen are the ones the decoder saw at the same edge.
	always @(posedge clk) begin
		decode_result_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("Timeout: no request or result moved for %0d cycles, %0d pending",
				         WatchdogLimit, pending_decodes.size());
				$display("Simulation FAILED");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (pending_decodes.size() == 0) begin
					report_mismatch($sformatf("result with no request pending, m_tdata 0x%0h",
					                          m_tdata));
				end else begin
					want = pending_decodes.pop_front();
					compare_field("mnemonic", 32'(m_tdata[5:0]), 32'(want.mn));
					compare_field("first_reg", 32'(m_tdata[11:6]), 32'(want.r0));
					compare_field("second_reg", 32'(m_tdata[17:12]), 32'(want.r1));
					compare_field("third_reg", 32'(m_tdata[23:18]), 32'(want.r2));
					compare_field("immediate_value", m_tdata[55:24], want.imm);
					compare_field("operand_count", 32'(m_tdata[57:56]), 32'(want.cnt));
					compare_field("error_code", 32'(m_tdata[59:58]), 32'(want.err));
					compare_field("line_out", m_tdata[91:60], want.line);
					if (want.err == cid_pkg::ERR_NONE) seen_mnemonics[want.mn] = 1'b1;
					else if (want.err == cid_pkg::ERR_SUBENC) subenc_count++;
					else unimpl_count++;
				end
				checked_count++;
			end
		end
	end

	// Main sequence: reset, the directed table, then the random requests with
	// one full drain in the middle, a quiet tail, and the final wait.
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if ($urandom_range(0, 3) == 0) idle_input($urandom_range(1, 9));
			send_request(directed_rows[i].word, directed_rows[i].line,
			             directed_rows[i].typed, directed_rows[i].want);
		end

		for (int i = 0; i < RandomRequests; i++) begin
			quiet_tail = (i >= RandomRequests - QuietTail);
			// Once, let the pipeline empty completely before going on.
			if (i == RandomRequests / 2) begin
				while (pending_decodes.size() != 0) idle_input(1);
			end
			if (!quiet_tail && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 9));
			send_request(random_word(), $urandom, 1'b0, '0);
		end

		idle_input(1);
		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d requests and checked %0d results, %0d with a bad sub-encoding",
		         sent_count, checked_count, subenc_count);
		$display("and %0d with an unimplemented opcode; %0d of 41 mnemonics decoded.",
		         unimpl_count, $countones(seen_mnemonics));
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
